// ===== sv/twcs_pkg.sv =====
// Shared types and constants for the textured wall column scaler.
package twcs_pkg;

    localparam int SCREEN_HEIGHT = 64;
    localparam int SCREEN_WIDTH  = 64;
    localparam int NUM_TEXTURES  = 4;

    localparam int TEX_SLOTS = 4;
    localparam int TEX_W     = 11;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_RESET = 64;

    localparam int COL_W  = 6;
    localparam int DIST_W = 16;
    localparam int SEL_W  = 2;
    localparam int FRAC_W = 16;
    localparam int PIX_W  = 12;
    localparam int OFS_W  = 20;

    localparam int FIX_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int H_NUM     = SCREEN_HEIGHT * 256;
    localparam int H_W       = $clog2(H_NUM + 1);
    localparam int ROWS_W    = $clog2(SCREEN_HEIGHT + 1);
    localparam int ROW_W     = $clog2(SCREEN_HEIGHT);

    localparam int DIV_NUM_W  = H_W + TEX_W + FRAC_BITS;
    localparam int DIV_DEN_W  = (DIST_W > H_W + 1) ? DIST_W : H_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
    localparam int STEP_NUM_W = TEX_W + FRAC_BITS;

    localparam int MUL_A_W = (FRAC_W > H_W) ? FRAC_W : H_W;
    localparam int MUL_P_W = MUL_A_W + TEX_W;

    typedef struct packed {
        logic [TEX_SLOTS-1:0][TEX_W-1:0] height;
        logic [TEX_SLOTS-1:0][TEX_W-1:0] width;
    } tex_cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== sv/twcs_regs.sv =====
// APB register file holding the texture dimensions.
module twcs_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [twcs_pkg::ADDR_W-1:0] paddr,
    input  logic [twcs_pkg::DATA_W-1:0] pwdata,
    output logic [twcs_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output twcs_pkg::tex_cfg_t          cfg
);
    import twcs_pkg::*;

    localparam int IDX_W = ADDR_W - 2;

    tex_cfg_t           cfg_reg;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-2:0]   slot;
    logic               wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign slot   = idx[IDX_W-1:1];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Even register indexes hold a height, odd ones a width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TEX_SLOTS; i++) begin
                cfg_reg.height[i] <= TEX_W'(REG_RESET);
                cfg_reg.width[i]  <= TEX_W'(REG_RESET);
            end
        end else if (wr_en) begin
            if (idx[0]) begin
                cfg_reg.width[slot] <= pwdata[TEX_W-1:0];
            end else begin
                cfg_reg.height[slot] <= pwdata[TEX_W-1:0];
            end
        end
    end

    always_comb begin
        if (idx[0]) begin
            prdata = DATA_W'(cfg_reg.width[slot]);
        end else begin
            prdata = DATA_W'(cfg_reg.height[slot]);
        end
    end

endmodule

// ===== sv/twcs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module twcs_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  twcs_pkg::div_req_t  req,
    output twcs_pkg::div_rsp_t  rsp
);
    import twcs_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // The numerator is left-aligned so that only the requested number of
    // steps is spent; after them the quotient sits in the low bits.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            den_reg <= req.den;
            quo_reg <= req.num << (DIV_CNT_W'(DIV_NUM_W) - req.iters);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= diff[DIV_DEN_W-1:0];
            end else begin
                rem_reg <= trial[DIV_DEN_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// ===== sv/textured_wall_column_scaler_unit.sv =====
// Top level of the textured wall column scaler: sequencer, row walk and output word.
//
//   channel  direction  handshake                  carries
//   cfg      in         psel/penable/pwrite/pready texture heights and widths
//   s_       in         s_valid/s_ready            column, distance, texture, hit
//   m_       out        m_valid/m_ready            pixel, texture, texel, last row
//
// One column takes the word and runs the wall height division; a bad item or a zero
// height ends there. Otherwise the texel step division and, when the wall is clipped,
// the start offset division follow, all on the one shared divider; then one word per
// drawn row (up to 64).
// Row words advance only when the output register is free or being taken.
// Reset is synchronous, active low, and returns the block to idle.
module textured_wall_column_scaler_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [twcs_pkg::ADDR_W-1:0] paddr,
    input  logic [twcs_pkg::DATA_W-1:0] pwdata,
    output logic [twcs_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [twcs_pkg::COL_W-1:0]  s_column,
    input  logic [twcs_pkg::DIST_W-1:0] s_distance,
    input  logic [twcs_pkg::SEL_W-1:0]  s_texture_select,
    input  logic [twcs_pkg::FRAC_W-1:0] s_hit_fraction,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [twcs_pkg::PIX_W-1:0]  m_pixel_index,
    output logic [twcs_pkg::SEL_W-1:0]  m_texture_index,
    output logic [twcs_pkg::OFS_W-1:0]  m_texel_offset,
    output logic                        m_last_row
);
    import twcs_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV_H     = 3'd1;
    localparam logic [2:0] S_DIV_STEP  = 3'd2;
    localparam logic [2:0] S_DIV_START = 3'd3;
    localparam logic [2:0] S_EMIT      = 3'd4;

    tex_cfg_t cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [2:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [TEX_W-1:0]  th_reg;
    logic [TEX_W-1:0]  tw_reg;
    logic              skip_reg;
    logic [H_W-1:0]    h_reg;
    logic [TEX_W-1:0]  tcol_reg;
    logic [MUL_P_W-1:0] prod_reg;
    logic [FIX_W-1:0]  step_reg;
    logic [FIX_W-1:0]  pos_reg;
    logic [ROWS_W-1:0] rows_left_reg;
    logic [ROW_W-1:0]  screen_row_reg;

    logic              m_valid_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [SEL_W-1:0]  tex_reg;
    logic [OFS_W-1:0]  ofs_reg;
    logic              last_reg;

    logic               accept;
    logic               bad_item;
    logic [DIST_W-1:0]  dist_eff;
    logic [H_W-1:0]     h_new;
    logic [H_W-1:0]     h_draw;
    logic [H_W-1:0]     row0_full;
    logic               clipped;
    logic               load;
    logic [TEX_W-1:0]   tmax;
    logic [FIX_W-FRAC_BITS-1:0] trow_full;
    logic [TEX_W-1:0]   trow;
    logic [MUL_A_W-1:0] mul_a;
    logic [TEX_W-1:0]   mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [MUL_P_W-1:0] ofs_sum;
    logic [PIX_W-1:0]   pix_sum;

    twcs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    twcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign bad_item = ({{(TEX_W - COL_W){1'b0}}, s_column} >= TEX_W'(SCREEN_WIDTH))
                   || ({1'b0, s_texture_select} >= (SEL_W + 1)'(NUM_TEXTURES));
    assign dist_eff = (s_distance == '0) ? DIST_W'(1) : s_distance;
    assign h_new    = div_rsp.quot[H_W-1:0];
    assign clipped  = (h_reg > H_W'(SCREEN_HEIGHT));
    assign h_draw   = clipped ? H_W'(SCREEN_HEIGHT) : h_reg;
    assign row0_full = H_W'(SCREEN_HEIGHT) - h_draw;
    assign load     = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    // Texel row of the current step, held at the last row of the texture.
    assign tmax      = (th_reg == '0) ? '0 : th_reg - 1'b1;
    assign trow_full = pos_reg[FIX_W-1:FRAC_BITS];
    assign trow      = (trow_full > (FIX_W - FRAC_BITS)'(tmax)) ? tmax
                                                               : trow_full[TEX_W-1:0];

    // The one multiplier serves the hit column, the clip offset and each row.
    always_comb begin
        mul_a = MUL_A_W'(trow);
        mul_b = tw_reg;
        case (state_reg)
            S_DIV_H: begin
                mul_a = MUL_A_W'(frac_reg);
                mul_b = tw_reg;
            end
            S_DIV_STEP: begin
                mul_a = MUL_A_W'(h_reg - H_W'(SCREEN_HEIGHT));
                mul_b = th_reg;
            end
            default: begin
                mul_a = MUL_A_W'(trow);
                mul_b = tw_reg;
            end
        endcase
    end

    assign mul_p   = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign ofs_sum = mul_p + MUL_P_W'(tcol_reg);
    assign pix_sum = PIX_W'(screen_row_reg) * PIX_W'(SCREEN_WIDTH) + PIX_W'(col_reg);

    always_comb begin
        state_next    = state_reg;
        div_req.start = 1'b0;
        div_req.num   = DIV_NUM_W'(H_NUM);
        div_req.den   = DIV_DEN_W'(dist_eff);
        div_req.iters = DIV_CNT_W'(H_W);
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV_H;
                end
            end
            S_DIV_H: begin
                div_req.num   = DIV_NUM_W'(th_reg) << FRAC_BITS;
                div_req.den   = DIV_DEN_W'(h_new);
                div_req.iters = DIV_CNT_W'(STEP_NUM_W);
                if (div_rsp.done) begin
                    if (skip_reg || (h_new == '0)) begin
                        state_next = S_IDLE;
                    end else begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV_STEP;
                    end
                end
            end
            S_DIV_STEP: begin
                div_req.num   = DIV_NUM_W'(prod_reg) << FRAC_BITS;
                div_req.den   = DIV_DEN_W'({h_reg, 1'b0});
                div_req.iters = DIV_CNT_W'(DIV_NUM_W);
                if (div_rsp.done) begin
                    if (clipped) begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV_START;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIV_START: begin
                if (div_rsp.done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load && (rows_left_reg == ROWS_W'(1))) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            rows_left_reg  <= '0;
            screen_row_reg <= '0;
            pos_reg        <= '0;
            step_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                rows_left_reg <= '0;
            end
            if ((state_reg == S_DIV_STEP) && div_rsp.done) begin
                step_reg <= div_rsp.quot[FIX_W-1:0];
                if (!clipped) begin
                    pos_reg        <= '0;
                    rows_left_reg  <= ROWS_W'(h_draw);
                    screen_row_reg <= row0_full[ROW_W:1];
                end
            end
            if ((state_reg == S_DIV_START) && div_rsp.done) begin
                pos_reg        <= div_rsp.quot[FIX_W-1:0];
                rows_left_reg  <= ROWS_W'(h_draw);
                screen_row_reg <= row0_full[ROW_W:1];
            end
            if (load) begin
                rows_left_reg  <= rows_left_reg - 1'b1;
                screen_row_reg <= screen_row_reg + 1'b1;
                pos_reg        <= pos_reg + step_reg;
            end
        end
    end

    // Item fields and the texture dimensions are captured when the word is taken.
    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg  <= s_column;
            sel_reg  <= s_texture_select;
            frac_reg <= s_hit_fraction;
            th_reg   <= cfg.height[s_texture_select];
            tw_reg   <= cfg.width[s_texture_select];
            skip_reg <= bad_item;
        end
        if ((state_reg == S_DIV_H) && div_rsp.done) begin
            h_reg <= h_new;
        end
        if (state_reg == S_DIV_H) begin
            tcol_reg <= mul_p[FRAC_BITS +: TEX_W];
        end
        if (state_reg == S_DIV_STEP) begin
            prod_reg <= mul_p;
        end
        if (load) begin
            pix_reg  <= pix_sum;
            tex_reg  <= sel_reg;
            ofs_reg  <= ofs_sum[OFS_W-1:0];
            last_reg <= (rows_left_reg == ROWS_W'(1));
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_index   = pix_reg;
    assign m_texture_index = tex_reg;
    assign m_texel_offset  = ofs_reg;
    assign m_last_row      = last_reg;

endmodule

// ===== sv/twcs_checker.sv =====
// Port-level checks for the textured wall column scaler, bound to the top level.
module twcs_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [twcs_pkg::PIX_W-1:0]  m_pixel_index,
    input logic [twcs_pkg::SEL_W-1:0]  m_texture_index,
    input logic [twcs_pkg::OFS_W-1:0]  m_texel_offset,
    input logic                        m_last_row
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output word valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_index)
            && $stable(m_texel_offset) && $stable(m_last_row))
        else $error("stalled output word changed");

    // Rows of one column follow each other without a gap while taken.
    a_column_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row |=> m_valid
            && (m_texture_index == $past(m_texture_index)))
        else $error("column ended before its last row");

    a_no_accept_mid_column: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_row |-> !s_ready)
        else $error("input ready while a column is still being drawn");

    a_accept_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a word was taken");

endmodule

bind textured_wall_column_scaler_unit twcs_checker u_twcs_checker (.*);
